### hdl/nsmi_pkg.sv
// Package: types, constants and codes for the Newton-Schulz inverse core.
`default_nettype none
package nsmi_pkg;

    localparam int MatrixSizeDefault   = 3;
    localparam int FractionBitsDefault = 24;
    localparam logic [30:0] ToleranceReset = 31'd168;
    localparam logic [15:0] MaxIterReset   = 16'd64;

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_X = 2'd1,
        ACT_START  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic {
        REG_TOLERANCE = 1'b0,
        REG_MAX_ITER  = 1'b1
    } reg_index_t;

    // Phases of one pass: R = X*A, X' = 2X - R*X (next X), E = A*X'
    typedef enum logic [1:0] {
        PH_XA = 2'd0,
        PH_RX = 2'd1,
        PH_AN = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_MUL   = 3'd2,
        ST_ACC   = 3'd3,
        ST_CHECK = 3'd4,
        ST_COPY  = 3'd5,
        ST_EMIT  = 3'd6
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] out_value;
        logic               last;
        logic               converged;
        logic [15:0]        passes;
    } out_item_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000) r = -32'sh8000_0000;
        else                               r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/newton_schulz_matrix_inverse_core.sv
// Top level: iterative Newton-Schulz matrix inverse over one shared multiplier.
// Loads are accepted only while idle; a start runs passes of 3*N^3 MACs.
// Each MAC steps through read, multiply and accumulate, each entry then has a
// store step, and a pass ends by copying the N^2 entries of the next X into X.
// After the last pass the N^2 result entries stream out, held back by m_ready.
// Reset (synchronous, active low) restores the control registers and idles the sequencer.
`default_nettype none
module newton_schulz_matrix_inverse_core #(
    parameter int MATRIX_SIZE   = nsmi_pkg::MatrixSizeDefault,
    parameter int FRACTION_BITS = nsmi_pkg::FractionBitsDefault
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire nsmi_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output nsmi_pkg::out_item_t     m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data
);
    localparam int Cells = MATRIX_SIZE * MATRIX_SIZE;
    localparam int CW    = $clog2(Cells);
    localparam int IW    = $clog2(MATRIX_SIZE);
    localparam int EW    = CW + 33;

    logic [31:0] mem_a [Cells];
    logic [31:0] mem_x [Cells];
    logic [31:0] mem_r [Cells];
    logic [31:0] mem_n [Cells];

    nsmi_pkg::state_t state_reg, state_next;
    nsmi_pkg::phase_t phase_reg, phase_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [30:0] tol_reg;
    logic [15:0] maxit_reg, pass_reg, pass_next;
    logic conv_reg, conv_next;
    logic signed [31:0] op_p_reg, op_q_reg;
    logic signed [63:0] prod_reg;
    logic signed [47:0] acc_reg, acc_next;
    logic [EW-1:0] err_reg, err_next;
    logic [CW-1:0] cell_reg, cell_next;
    logic [15:0] cap;

    logic [CW-1:0] ij, ik, kj;
    logic signed [31:0] sat_acc, xi, two_x;
    logic signed [47:0] diff, ed;
    logic signed [63:0] rounded;
    logic [31:0] pv, qv;
    logic wr_r, wr_n;

    assign ij = CW'(i_reg * MATRIX_SIZE + j_reg);
    assign ik = CW'(i_reg * MATRIX_SIZE + k_reg);
    assign kj = CW'(k_reg * MATRIX_SIZE + j_reg);
    assign cap = (maxit_reg == 16'd0) ? 16'd1 : maxit_reg;
    assign s_ready = (state_reg == nsmi_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Select multiplier operands for the current phase
    always_comb begin
        case (phase_reg)
            nsmi_pkg::PH_XA: begin pv = mem_x[ik]; qv = mem_a[kj]; end
            nsmi_pkg::PH_RX: begin pv = mem_r[ik]; qv = mem_x[kj]; end
            default:         begin pv = mem_a[ik]; qv = mem_n[kj]; end
        endcase
    end

    assign rounded = (prod_reg + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    assign sat_acc = nsmi_pkg::sat32(acc_reg);
    assign xi      = mem_x[ij];
    assign diff    = 48'(2 * 48'(xi)) - 48'(sat_acc);
    assign two_x   = nsmi_pkg::sat32(diff);
    assign ed      = 48'(sat_acc) - ((i_reg == j_reg) ? (48'sd1 <<< FRACTION_BITS) : 48'sd0);

    // Sequencer: MACs step through read, multiply and accumulate; then store or error accumulate, copy and emit
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg;
        acc_next = acc_reg;
        err_next = err_reg;
        pass_next = pass_reg;
        conv_next = conv_reg;
        cell_next = cell_reg;
        wr_r = 1'b0;
        wr_n = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            nsmi_pkg::ST_IDLE: begin
                if (s_valid && s_data.action == nsmi_pkg::ACT_START) begin
                    state_next = nsmi_pkg::ST_READ;
                    phase_next = nsmi_pkg::PH_XA;
                    i_next = '0; j_next = '0; k_next = '0;
                    acc_next = '0; err_next = '0; pass_next = '0;
                end
            end
            nsmi_pkg::ST_READ: state_next = nsmi_pkg::ST_MUL;
            nsmi_pkg::ST_MUL:  state_next = nsmi_pkg::ST_ACC;
            nsmi_pkg::ST_ACC: begin
                acc_next = acc_reg + 48'(rounded);
                state_next = nsmi_pkg::ST_READ;
                if (k_reg != IW'(MATRIX_SIZE - 1)) begin
                    k_next = k_reg + 1'b1;
                end else begin
                    k_next = '0;
                    state_next = nsmi_pkg::ST_CHECK;
                end
            end
            nsmi_pkg::ST_CHECK: begin
                // Finish one output entry of the current product
                acc_next = '0;
                case (phase_reg)
                    nsmi_pkg::PH_XA: wr_r = 1'b1;
                    nsmi_pkg::PH_RX: wr_n = 1'b1;
                    default: err_next = err_reg + EW'(ed < 0 ? -ed : ed);
                endcase
                state_next = nsmi_pkg::ST_READ;
                if (j_reg != IW'(MATRIX_SIZE - 1)) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    j_next = '0;
                    if (i_reg != IW'(MATRIX_SIZE - 1)) begin
                        i_next = i_reg + 1'b1;
                    end else begin
                        i_next = '0;
                        case (phase_reg)
                            nsmi_pkg::PH_XA: phase_next = nsmi_pkg::PH_RX;
                            nsmi_pkg::PH_RX: phase_next = nsmi_pkg::PH_AN;
                            default: begin
                                pass_next = pass_reg + 16'd1;
                                conv_next = (err_next < EW'(tol_reg));
                                cell_next = '0;
                                state_next = nsmi_pkg::ST_COPY;
                            end
                        endcase
                    end
                end
            end
            nsmi_pkg::ST_COPY: begin
                // Move next X into current X, one entry a cycle
                if (cell_reg != CW'(Cells - 1)) begin
                    cell_next = cell_reg + 1'b1;
                end else begin
                    cell_next = '0;
                    err_next = '0;
                    if (conv_reg || pass_reg >= cap) begin
                        state_next = nsmi_pkg::ST_EMIT;
                    end else begin
                        state_next = nsmi_pkg::ST_READ;
                        phase_next = nsmi_pkg::PH_XA;
                    end
                end
            end
            nsmi_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (i_reg == IW'(MATRIX_SIZE - 1) && j_reg == IW'(MATRIX_SIZE - 1)) begin
                        i_next = '0; j_next = '0;
                        state_next = nsmi_pkg::ST_IDLE;
                    end else if (j_reg == IW'(MATRIX_SIZE - 1)) begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: state_next = nsmi_pkg::ST_IDLE;
        endcase
    end

    // Hold result fields from the current X store
    always_comb begin
        m_data.out_row   = 3'(i_reg);
        m_data.out_col   = 3'(j_reg);
        m_data.out_value = xi;
        m_data.last      = (i_reg == IW'(MATRIX_SIZE - 1)) && (j_reg == IW'(MATRIX_SIZE - 1));
        m_data.converged = conv_reg;
        m_data.passes    = pass_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nsmi_pkg::ST_IDLE;
            phase_reg <= nsmi_pkg::PH_XA;
            i_reg <= '0; j_reg <= '0; k_reg <= '0;
            pass_reg <= '0;
            conv_reg <= 1'b0;
            cell_reg <= '0;
            err_reg <= '0;
            tol_reg <= nsmi_pkg::ToleranceReset;
            maxit_reg <= nsmi_pkg::MaxIterReset;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg <= i_next; j_reg <= j_next; k_reg <= k_next;
            pass_reg <= pass_next;
            conv_reg <= conv_next;
            cell_reg <= cell_next;
            err_reg <= err_next;
            if (cfg_valid) begin
                if (cfg_index == nsmi_pkg::REG_TOLERANCE) tol_reg <= cfg_data[30:0];
                else                                      maxit_reg <= cfg_data[15:0];
            end
        end
    end

    // Datapath registers and matrix stores
    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        op_p_reg <= pv;
        op_q_reg <= qv;
        prod_reg <= 64'(op_p_reg) * 64'(op_q_reg);
        if (wr_r) mem_r[ij] <= sat_acc;
        if (wr_n) mem_n[ij] <= two_x;
        if (state_reg == nsmi_pkg::ST_COPY) mem_x[cell_reg] <= mem_n[cell_reg];
        if (state_reg == nsmi_pkg::ST_IDLE && s_valid &&
            {1'b0, s_data.row} < 4'(MATRIX_SIZE) && {1'b0, s_data.col} < 4'(MATRIX_SIZE)) begin
            if (s_data.action == nsmi_pkg::ACT_LOAD_A)
                mem_a[CW'(s_data.row * MATRIX_SIZE + s_data.col)] <= s_data.value;
            if (s_data.action == nsmi_pkg::ACT_LOAD_X)
                mem_x[CW'(s_data.row * MATRIX_SIZE + s_data.col)] <= s_data.value;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("ready while emitting");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == nsmi_pkg::ACT_START |=> !s_ready)
        else $error("start did not occupy sequencer");
    a_pass_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pass_reg != 16'd0) else $error("emit without pass");
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last |=> s_ready) else $error("last did not end run");

endmodule
`default_nettype wire
